// File: design/jcles_pkg.sv
`timescale 1ns / 1ps

package jcles_pkg;

  // Scan phase
  typedef enum logic [1:0] {
    PhSoi  = 2'd0,
    PhHdr  = 2'd1,
    PhSkip = 2'd2,
    PhDone = 2'd3
  } phase_e;

  // Verdict codes as seen on the output port
  typedef enum logic [1:0] {
    VerdictClean     = 2'd0,
    VerdictExploit   = 2'd1,
    VerdictMalformed = 2'd2
  } verdict_e;

  // Marker bytes and limits
  localparam logic [7:0]  MarkerPrefix = 8'hFF;
  localparam logic [7:0]  SoiCode      = 8'hD8;
  localparam logic [7:0]  ComCode      = 8'hFE;
  localparam logic [7:0]  SosCode      = 8'hDA;
  localparam logic [15:0] MinLength    = 16'd2;
  localparam logic [2:0]  SoiBytes     = 3'd2;
  localparam logic [2:0]  HdrBytes     = 3'd4;

  // Scanner state
  typedef struct packed {
    phase_e      phase;
    logic [31:0] window;  // newest byte in the low byte
    logic [2:0]  fill;
    logic [15:0] skip;
  } scan_state_t;

  localparam scan_state_t StateReset = '{
    phase:  PhSoi,
    window: 32'd0,
    fill:   3'd0,
    skip:   16'd0
  };

  // One step's outcome
  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } scan_result_t;

endpackage

// File: design/jcles_step.sv
`timescale 1ns / 1ps

// Next-state and verdict logic for one byte of the file.
module jcles_step import jcles_pkg::*; (
  input  scan_state_t  state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  output scan_state_t  state_o,
  output scan_result_t result_o
);

  logic [31:0] win_shift;
  logic [2:0]  fill_inc;
  logic [7:0]  hdr_b0;
  logic [7:0]  hdr_b1;
  logic [15:0] hdr_len;
  logic        soi_done;
  logic        soi_match;
  logic        hdr_done;
  logic        hdr_repeat_ff;
  logic        hdr_skip;
  logic [15:0] skip_len;
  logic [15:0] skip_dec;

  // Shared datapath terms
  assign win_shift     = {state_i.window[23:0], data_byte_i};
  assign fill_inc      = state_i.fill + 3'd1;
  assign hdr_b0        = win_shift[31:24];
  assign hdr_b1        = win_shift[23:16];
  assign hdr_len       = win_shift[15:0];
  assign soi_done      = (fill_inc >= SoiBytes);
  assign soi_match     = (win_shift[15:0] == {MarkerPrefix, SoiCode});
  assign hdr_done      = (fill_inc == HdrBytes);
  assign hdr_repeat_ff = (hdr_b0 == MarkerPrefix) && (hdr_b1 == MarkerPrefix);
  // Ordinary segment: walk over its payload
  assign hdr_skip      = (hdr_b0 == MarkerPrefix) && (hdr_b1 != MarkerPrefix)
                         && (hdr_b1 != SosCode) && (hdr_len >= MinLength);
  assign skip_len      = hdr_len - MinLength;
  assign skip_dec      = state_i.skip - 16'd1;

  // Verdict
  always_comb begin
    result_o = '{valid: 1'b0, verdict: VerdictClean};
    unique case (state_i.phase)
      PhSoi: begin
        if (soi_done && !soi_match) begin
          result_o = '{valid: 1'b1, verdict: VerdictClean};
        end
      end
      PhHdr: begin
        if (hdr_done) begin
          priority if (hdr_repeat_ff) begin
            result_o.valid = 1'b0;
          end else if (hdr_b0 == MarkerPrefix && hdr_b1 == ComCode
                       && hdr_len < MinLength) begin
            result_o = '{valid: 1'b1, verdict: VerdictExploit};
          end else if (hdr_b0 != MarkerPrefix) begin
            result_o = '{valid: 1'b1, verdict: VerdictMalformed};
          end else if (hdr_b1 == SosCode) begin
            result_o = '{valid: 1'b1, verdict: VerdictClean};
          end else if (hdr_len < MinLength) begin
            result_o = '{valid: 1'b1, verdict: VerdictExploit};
          end else begin
            result_o.valid = 1'b0;
          end
        end
      end
      PhSkip, PhDone: begin
        result_o.valid = 1'b0;
      end
      default: begin
        result_o.valid = 1'b0;
      end
    endcase
    // File ended with nothing decided
    if (!result_o.valid && last_byte_i && state_i.phase != PhDone) begin
      result_o = '{valid: 1'b1, verdict: VerdictClean};
    end
  end

  // Next state
  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PhSoi: begin
        state_o.window = win_shift;
        state_o.fill   = fill_inc;
        if (soi_done && soi_match) begin
          state_o.phase  = PhHdr;
          state_o.window = 32'd0;
          state_o.fill   = 3'd0;
        end
      end
      PhHdr: begin
        state_o.window = win_shift;
        state_o.fill   = fill_inc;
        if (hdr_done) begin
          if (hdr_repeat_ff) begin
            // drop the first FF, the next byte completes a new header
            state_o.window = {8'd0, win_shift[23:0]};
            state_o.fill   = 3'd3;
          end else if (hdr_skip) begin
            state_o.window = 32'd0;
            state_o.fill   = 3'd0;
            state_o.skip   = skip_len;
            state_o.phase  = (skip_len == 16'd0) ? PhHdr : PhSkip;
          end
        end
      end
      PhSkip: begin
        state_o.skip = skip_dec;
        if (skip_dec == 16'd0) begin
          state_o.phase  = PhHdr;
          state_o.window = 32'd0;
          state_o.fill   = 3'd0;
        end
      end
      PhDone: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    // End of file restarts the scan; a verdict parks it until then
    if (last_byte_i) begin
      state_o = StateReset;
    end else if (result_o.valid) begin
      state_o.phase = PhDone;
    end
  end

endmodule

// File: design/jpeg_comment_length_exploit_scan_unit.sv
`timescale 1ns / 1ps

// Channel | handshake                | payload
// --------+--------------------------+-------------------------------
// in      | in_valid_i / in_ready_o  | data_byte_i[7:0], last_byte_i
// out     | out_valid_o / out_ready_i| verdict_o[1:0]
//
// One byte per cycle unless stalled: each accepted byte updates the scan
// state in the same edge, and any verdict lands in the output register.
// in_ready_o is high while the output register is empty or being drained.
// A stalled output holds one verdict; while out_valid_o is unanswered
// in_ready_o stays low and every byte waits, needed verdict or not.
// Reset (rst_ni low, asynchronous) returns to the start-of-image check.
module jpeg_comment_length_exploit_scan_unit import jcles_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o
);

  scan_state_t  state_q;
  scan_state_t  state_d;
  scan_result_t step_res;
  logic         out_valid_q;
  verdict_e     verdict_q;
  logic         in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  jcles_step u_step (
    .state_i     (state_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && step_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_fire && step_res.valid) begin
      verdict_q <= step_res.verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule
